/* rtl/scch_pkg.sv */
// ----------------------------------------------------------------------------
// scch_pkg
// Types and constants shared by the histogram cube controller and datapath.
// ----------------------------------------------------------------------------
package scch_pkg;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;
    localparam int E_REG_W    = 7;
    localparam int T_REG_W    = 5;
    localparam int CHAN_W     = 16;
    localparam int VAL_W      = 32;
    localparam int TOTAL_W    = 48;

    localparam logic [CFG_IDX_W-1:0] CFG_ENERGY = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME   = 1'd1;

    localparam logic [E_REG_W-1:0] E_REG_RST = 7'd64;
    localparam logic [T_REG_W-1:0] T_REG_RST = 5'd16;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    typedef enum logic [1:0] {
        MODE_SYM    = 2'd0,
        MODE_SINGLE = 2'd1,
        MODE_SET    = 2'd2,
        MODE_GET    = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD_A,
        ST_WR_A,
        ST_RD_B,
        ST_WR_B,
        ST_SET_ADD,
        ST_PUSH
    } t_state;

    typedef struct packed {
        logic load;
        logic clr_wr;
        logic wr;
        logic sel_b;
        logic capture;
        logic set_add;
        logic push;
    } t_cmd;

    typedef struct packed {
        logic  ok;
        t_mode mode;
        logic  diag;
        logic  clr_last;
        logic  out_busy;
    } t_stat;

endpackage

/* rtl/symmetric_coincidence_histogram_cube_core.sv */
// ----------------------------------------------------------------------------
// symmetric_coincidence_histogram_cube_core
// Three-dimensional count histogram (energy x energy x time) with fill,
// set and get requests and a saturating running total of all counts.
// ----------------------------------------------------------------------------
// Sequence: an accepted item reads entry A; if out of range it goes straight to
//   the push. Otherwise get captures the count, fills and set write A, set
//   adds its new value to the total, and a symmetric fill off the diagonal
//   reads and writes the mirrored entry too. Push waits while output stalls.
// Input: a new item is accepted only after the last result has been pushed;
//   the single-port count memory does one read-modify-write per entry, two
//   for a mirrored fill. Reset: synchronous, active low; afterwards a clear
//   pass writes every memory entry, with s_axis_tready low.
module symmetric_coincidence_histogram_cube_core
    import scch_pkg::*;
#(
    parameter int MAX_ENERGY_CHANS = 64,
    parameter int MAX_TIME_CHANS   = 16,
    parameter int COUNT_BITS       = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // first_energy, second_energy, time_bin, new_value
    input  logic [79:0]           i_s_axis_tdata,
    // mode
    input  logic [1:0]            i_s_axis_tuser,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // read_count, total_counts
    output logic [79:0]           o_m_axis_tdata,
    // in_range
    output logic                  o_m_axis_tuser,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    t_cmd                cmd;
    t_stat               stat;
    logic [VAL_W-1:0]    read_count;
    logic                in_range;
    logic [TOTAL_W-1:0]  total;

    scch_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .o_s_tready (o_s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    scch_dp #(
        .MAX_ENERGY_CHANS (MAX_ENERGY_CHANS),
        .MAX_TIME_CHANS   (MAX_TIME_CHANS),
        .COUNT_BITS       (COUNT_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_mode       (i_s_axis_tuser),
        .i_x          (i_s_axis_tdata[15:0]),
        .i_y          (i_s_axis_tdata[31:16]),
        .i_t          (i_s_axis_tdata[47:32]),
        .i_val        (i_s_axis_tdata[79:48]),
        .o_m_tvalid   (o_m_axis_tvalid),
        .i_m_tready   (i_m_axis_tready),
        .o_read_count (read_count),
        .o_in_range   (in_range),
        .o_total      (total)
    );

    assign o_m_axis_tdata = {total, read_count};
    assign o_m_axis_tuser = in_range;

endmodule

/* rtl/scch_ctrl.sv */
// ----------------------------------------------------------------------------
// scch_ctrl
// Sequencer: memory clear after reset, then per-item read-modify-write steps.
// ----------------------------------------------------------------------------
module scch_ctrl
    import scch_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_s_tvalid,
    output logic  o_s_tready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_RD_A;
                end
            end
            ST_RD_A: begin
                n_state = i_stat.ok ? ST_WR_A : ST_PUSH;
            end
            ST_WR_A: begin
                case (i_stat.mode)
                    MODE_GET: begin
                        o_cmd.capture = 1'b1;
                        n_state       = ST_PUSH;
                    end
                    MODE_SET: begin
                        o_cmd.wr = 1'b1;
                        n_state  = ST_SET_ADD;
                    end
                    MODE_SYM: begin
                        o_cmd.wr = 1'b1;
                        n_state  = i_stat.diag ? ST_PUSH : ST_RD_B;
                    end
                    default: begin
                        o_cmd.wr = 1'b1;
                        n_state  = ST_PUSH;
                    end
                endcase
            end
            ST_RD_B: begin
                o_cmd.sel_b = 1'b1;
                n_state     = ST_WR_B;
            end
            ST_WR_B: begin
                o_cmd.sel_b = 1'b1;
                o_cmd.wr    = 1'b1;
                n_state     = ST_PUSH;
            end
            ST_SET_ADD: begin
                o_cmd.set_add = 1'b1;
                n_state       = ST_PUSH;
            end
            ST_PUSH: begin
                if (!i_stat.out_busy) begin
                    o_cmd.push = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

endmodule

/* rtl/scch_dp.sv */
// ----------------------------------------------------------------------------
// scch_dp
// Datapath: limit registers, count memory, saturating count and total
// arithmetic, result register.
// ----------------------------------------------------------------------------
module scch_dp
    import scch_pkg::*;
#(
    parameter int MAX_ENERGY_CHANS = 64,
    parameter int MAX_TIME_CHANS   = 16,
    parameter int COUNT_BITS       = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_stat                 o_stat,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic [1:0]            i_mode,
    input  logic [CHAN_W-1:0]     i_x,
    input  logic [CHAN_W-1:0]     i_y,
    input  logic [CHAN_W-1:0]     i_t,
    input  logic [VAL_W-1:0]      i_val,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [VAL_W-1:0]      o_read_count,
    output logic                  o_in_range,
    output logic [TOTAL_W-1:0]    o_total
);

    localparam int    EW    = $clog2(MAX_ENERGY_CHANS);
    localparam int    TW    = (MAX_TIME_CHANS > 1) ? $clog2(MAX_TIME_CHANS) : 1;
    localparam longint EE   = longint'(MAX_ENERGY_CHANS) * longint'(MAX_ENERGY_CHANS);
    localparam longint DEPTH = EE * longint'(MAX_TIME_CHANS);
    localparam int    AW    = $clog2(DEPTH);
    localparam longint CMAX = (64'd1 << COUNT_BITS) - 64'd1;
    localparam int    CB    = COUNT_BITS;

    logic [CB-1:0] mem [DEPTH];

    logic [E_REG_W-1:0]  r_elim;
    logic [T_REG_W-1:0]  r_tlim;
    logic [AW-1:0]       r_clr;
    t_mode               r_mode;
    logic [EW-1:0]       r_x;
    logic [EW-1:0]       r_y;
    logic [TW-1:0]       r_t;
    logic [CB-1:0]       r_val;
    logic                r_ok;
    logic [CB-1:0]       r_rdata;
    logic [CB-1:0]       r_cap;
    logic [TOTAL_W-1:0]  r_total;
    logic [TOTAL_W-1:0]  n_total;
    logic                r_ovalid;
    logic [VAL_W-1:0]    r_orc;
    logic                r_ook;
    logic [TOTAL_W-1:0]  r_otot;

    logic [AW-1:0]       a_addr;
    logic [AW-1:0]       b_addr;
    logic [AW-1:0]       mem_addr;
    logic                mem_we;
    logic [CB-1:0]       mem_wd;
    logic                ok_in;
    logic                diag;
    logic [1:0]          amt;
    logic [CB:0]         fsum;
    logic                fsat;
    logic [CB-1:0]       fnew;
    logic [CB-1:0]       froom;
    logic [1:0]          fadd;
    logic [TOTAL_W:0]    tsum;
    logic [TOTAL_W:0]    ssum;
    logic [TOTAL_W-1:0]  old_ext;

    // limit registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elim <= E_REG_RST;
            r_tlim <= T_REG_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ENERGY: r_elim <= i_cfg_wdata[E_REG_W-1:0];
                CFG_TIME:   r_tlim <= i_cfg_wdata[T_REG_W-1:0];
                default: ;
            endcase
        end
    end

    assign ok_in = (i_x < CHAN_W'(MAX_ENERGY_CHANS)) && (i_x < CHAN_W'(r_elim)) &&
                   (i_y < CHAN_W'(MAX_ENERGY_CHANS)) && (i_y < CHAN_W'(r_elim)) &&
                   (i_t < CHAN_W'(MAX_TIME_CHANS))   && (i_t < CHAN_W'(r_tlim));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode <= t_mode'(i_mode);
            r_x    <= i_x[EW-1:0];
            r_y    <= i_y[EW-1:0];
            r_t    <= (MAX_TIME_CHANS > 1) ? i_t[TW-1:0] : '0;
            r_val  <= (i_val > VAL_W'(CMAX)) ? CB'(CMAX) : i_val[CB-1:0];
            r_ok   <= ok_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clr_wr) begin
            r_clr <= r_clr + AW'(1);
        end
    end

    assign a_addr = AW'(r_x) + AW'(r_y) * AW'(MAX_ENERGY_CHANS) + AW'(r_t) * AW'(EE);
    assign b_addr = AW'(r_y) + AW'(r_x) * AW'(MAX_ENERGY_CHANS) + AW'(r_t) * AW'(EE);
    assign diag   = (r_x == r_y);

    // saturating fill
    assign amt   = (r_mode == MODE_SYM && diag) ? 2'd2 : 2'd1;
    assign fsum  = {1'b0, r_rdata} + (CB+1)'(amt);
    assign fsat  = fsum > (CB+1)'(CMAX);
    assign fnew  = fsat ? CB'(CMAX) : fsum[CB-1:0];
    assign froom = CB'(CMAX) - r_rdata;
    assign fadd  = fsat ? froom[1:0] : amt;

    assign mem_addr = i_cmd.clr_wr ? r_clr : (i_cmd.sel_b ? b_addr : a_addr);
    assign mem_we   = i_cmd.clr_wr | i_cmd.wr;
    assign mem_wd   = i_cmd.clr_wr ? '0 : ((r_mode == MODE_SET) ? r_val : fnew);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wd;
        end
        r_rdata <= mem[mem_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cap <= '0;
        end else if (i_cmd.capture) begin
            r_cap <= r_rdata;
        end
    end

    // running total
    assign old_ext = TOTAL_W'(r_rdata);
    assign tsum    = {1'b0, r_total} + (TOTAL_W+1)'(fadd);
    assign ssum    = {1'b0, r_total} + (TOTAL_W+1)'(r_val);

    always_comb begin
        n_total = r_total;
        if (i_cmd.wr) begin
            if (r_mode == MODE_SET) begin
                if (r_total != TOTAL_MAX) begin
                    n_total = (old_ext <= r_total) ? (r_total - old_ext) : '0;
                end
            end else begin
                n_total = (tsum >= {1'b0, TOTAL_MAX}) ? TOTAL_MAX : tsum[TOTAL_W-1:0];
            end
        end else if (i_cmd.set_add) begin
            n_total = (ssum >= {1'b0, TOTAL_MAX}) ? TOTAL_MAX : ssum[TOTAL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
        end else begin
            r_total <= n_total;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.push) begin
            r_ovalid <= 1'b1;
        end else if (i_m_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_orc  <= VAL_W'(r_cap);
            r_ook  <= r_ok;
            r_otot <= r_total;
        end
    end

    assign o_m_tvalid   = r_ovalid;
    assign o_read_count = r_orc;
    assign o_in_range   = r_ook;
    assign o_total      = r_otot;

    assign o_stat.ok       = r_ok;
    assign o_stat.mode     = r_mode;
    assign o_stat.diag     = diag;
    assign o_stat.clr_last = (r_clr == AW'(DEPTH - 1));
    assign o_stat.out_busy = r_ovalid & ~i_m_tready;

endmodule

/* rtl/scch_checker.sv */
// ----------------------------------------------------------------------------
// scch_checker
// Port-level checks for the histogram cube core, bound to the top level.
// ----------------------------------------------------------------------------
module scch_checker (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_s_axis_tready,
    input logic                  o_m_axis_tvalid,
    input logic                  i_m_axis_tready,
    input logic [79:0]           o_m_axis_tdata,
    input logic                  o_m_axis_tuser
);

    // no result right after reset
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    // memory clear holds off input
    a_rst_in: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_s_axis_tready)
        else $error("input ready during clear");

    // out-of-range item reads zero
    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser |-> o_m_axis_tdata[31:0] == 32'd0)
        else $error("nonzero read_count when out of range");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("stalled result changed");

endmodule

bind symmetric_coincidence_histogram_cube_core scch_checker u_scch_checker (.*);
